[sv/prc_pkg.sv]
`default_nettype none
package prc_pkg;

	localparam int HalfDepth = 1024;
	localparam int HalfAw    = $clog2(HalfDepth);
	localparam int AddrW     = HalfAw + 1;
	localparam int ByteW     = 8;
	localparam int ClrCntW   = HalfAw + 1;
	localparam int IndexW    = 6;
	localparam int LevelW    = 8;
	localparam int FieldW    = 3;
	localparam int InDataW   = 24;
	localparam int OutDataW  = 32;

	localparam logic [IndexW-1:0] PlayfieldBase = IndexW'(4);
	localparam logic [IndexW-1:0] MotionBase    = IndexW'(20);

	typedef struct packed {
		logic              hit;
		logic [IndexW-1:0] palette_index;
		logic [LevelW-1:0] red;
		logic [LevelW-1:0] green;
		logic [LevelW-1:0] blue;
	} prc_result_t;

	function automatic logic [LevelW-1:0] scale_level(
		input logic [FieldW-1:0] field,
		input logic [FieldW-1:0] intensity
	);
		logic [2*FieldW-1:0] prod;
		prod = (2*FieldW)'(field) * (2*FieldW)'(intensity);
		return LevelW'({prod, 2'b00}) + LevelW'(prod);
	endfunction

endpackage
`default_nettype wire

[sv/prc_ram.sv]
`default_nettype none
module prc_ram #(
	parameter int Depth = 1024,
	parameter int Width = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/prc_decode.sv]
`default_nettype none
module prc_decode
	import prc_pkg::*;
(
	input  wire logic [HalfAw-1:0] low_addr,
	input  wire logic [ByteW-1:0]  lo_byte,
	input  wire logic [ByteW-1:0]  hi_byte,
	output prc_result_t            result
);

	logic [FieldW-1:0] intensity;
	logic [FieldW-1:0] red_field;
	logic [FieldW-1:0] green_field;
	logic [FieldW-1:0] blue_field;

	assign intensity   = hi_byte[3:1];
	assign red_field   = {hi_byte[0], lo_byte[7:6]};
	assign green_field = lo_byte[5:3];
	assign blue_field  = lo_byte[2:0];

	always_comb begin
		result.hit           = 1'b1;
		result.palette_index = '0;
		if (low_addr[9:4] == '0) begin
			result.palette_index = PlayfieldBase + IndexW'(low_addr[3:0]);
		end else if (low_addr[9:8] == '0 && low_addr[3:0] == '0) begin
			result.palette_index = MotionBase + IndexW'(low_addr[7:4]);
		end else if (low_addr[7:0] == '0) begin
			result.palette_index = IndexW'(low_addr[9:8]);
		end else begin
			result.hit = 1'b0;
		end
		result.red   = scale_level(red_field, intensity);
		result.green = scale_level(green_field, intensity);
		result.blue  = scale_level(blue_field, intensity);
	end

endmodule
`default_nettype wire

[sv/palette_ram_color_decoder.sv]
// Channel   Dir  tdata fields (lowest bit up)                       Other
// s_axis    in   address[10:0], write_data[18:11], zero pad to 24     -
// m_axis    out  palette_index[5:0], red[13:6], green[21:14],
//                blue[29:22], zero pad to 32                          -
//
// One item per cycle unless m_axis stalls; results pass the read stage, then out_q.
// The store is two 1024 x 8 RAMs; each item writes one half and reads the other.
// After reset a clearing pass zeroes both halves; s_axis_tready stays low while it runs.
// Writes that hit no palette entry are dropped after the store update.
// A stalled m_axis holds the result register and the read stage behind it.
`default_nettype none
module palette_ram_color_decoder
	import prc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [InDataW-1:0]  s_axis_tdata,  // address, write_data
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic      [OutDataW-1:0] m_axis_tdata   // palette_index, red, green, blue
);

	logic [ClrCntW-1:0] clr_cnt_q;
	logic               clearing;
	logic               in_acc;
	logic               advance;

	logic               valid_s1;
	logic [HalfAw-1:0]  addr_s1;
	logic               hi_s1;
	logic [ByteW-1:0]   data_s1;

	logic               out_valid_q;
	prc_result_t        out_q;

	logic [AddrW-1:0]   in_addr;
	logic [ByteW-1:0]   in_byte;
	logic               lo_we;
	logic               hi_we;
	logic [HalfAw-1:0]  waddr;
	logic [ByteW-1:0]   wdata;
	logic [ByteW-1:0]   rd_lo;
	logic [ByteW-1:0]   rd_hi;
	logic [ByteW-1:0]   lo_byte;
	logic [ByteW-1:0]   hi_byte;
	prc_result_t        result;

	assign in_addr  = s_axis_tdata[AddrW-1:0];
	assign in_byte  = s_axis_tdata[AddrW+ByteW-1:AddrW];

	assign clearing      = clr_cnt_q != ClrCntW'(HalfDepth);
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !clearing && (!valid_s1 || advance);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + ClrCntW'(1);
		end
	end

	assign lo_we = clearing || (in_acc && !in_addr[AddrW-1]);
	assign hi_we = clearing || (in_acc && in_addr[AddrW-1]);
	assign waddr = clearing ? clr_cnt_q[HalfAw-1:0] : in_addr[HalfAw-1:0];
	assign wdata = clearing ? '0 : in_byte;

	prc_ram #(.Depth(HalfDepth), .Width(ByteW)) u_lo_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (in_addr[HalfAw-1:0]),
		.rdata (rd_lo)
	);

	prc_ram #(.Depth(HalfDepth), .Width(ByteW)) u_hi_ram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (in_addr[HalfAw-1:0]),
		.rdata (rd_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1 <= in_addr[HalfAw-1:0];
			hi_s1   <= in_addr[AddrW-1];
			data_s1 <= in_byte;
		end
	end

	assign lo_byte = hi_s1 ? rd_lo : data_s1;
	assign hi_byte = hi_s1 ? data_s1 : rd_hi;

	prc_decode u_decode (
		.low_addr (addr_s1),
		.lo_byte  (lo_byte),
		.hi_byte  (hi_byte),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && result.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OutDataW'({out_q.blue, out_q.green, out_q.red, out_q.palette_index});

`ifndef ASSERT_OFF
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("item taken during clearing pass");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted item missing from read stage");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(addr_s1) && $stable(data_s1))
		else $error("read stage lost item under stall");

	a_clear_bound: assert property (@(posedge clk) disable iff (!arst_n)
		clr_cnt_q <= ClrCntW'(HalfDepth))
		else $error("clear counter overrun");
`endif

endmodule
`default_nettype wire

[test/tb_palette_ram_color_decoder.sv]
`timescale 1ns / 100ps

module tb_palette_ram_color_decoder;
	import prc_pkg::*;

	localparam int ClkHalf    = 4;
	localparam int ResetCyc   = 9;
	localparam int CycleLimit = 200000;
	localparam int HoldCyc    = 300;
	localparam int DrainCyc   = 8;

	typedef struct {
		logic [IndexW-1:0] palette_index;
		logic [LevelW-1:0] red;
		logic [LevelW-1:0] green;
		logic [LevelW-1:0] blue;
	} palette_color_t;

	class palette_scoreboard;
		logic [ByteW-1:0] color_bytes [2*HalfDepth];
		palette_color_t   expected_colors [$];
		int               errors;

		function new();
			foreach (color_bytes[i])
				color_bytes[i] = '0;
			errors = 0;
		endfunction

		function automatic logic [LevelW-1:0] level(logic [FieldW-1:0] field,
			logic [FieldW-1:0] intensity);
			return LevelW'(5 * int'(field) * int'(intensity));
		endfunction

		task automatic report(string what, int got, int want);
			$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
			errors++;
		endtask

		function automatic int pending();
			return expected_colors.size();
		endfunction

		task automatic note_write(logic [AddrW-1:0] addr, logic [ByteW-1:0] data);
			logic [HalfAw-1:0] half_addr;
			logic [11:0]       word;
			logic [FieldW-1:0] intensity;
			palette_color_t    colour;
			half_addr = addr[HalfAw-1:0];
			color_bytes[addr] = data;
			word = {color_bytes[{1'b1, half_addr}][3:0], color_bytes[{1'b0, half_addr}]};
			intensity = word[11:9];
			if (half_addr[9:4] == '0)
				colour.palette_index = PlayfieldBase + IndexW'(half_addr[3:0]);
			else if (half_addr[3:0] == '0 && half_addr[9:8] == '0)
				colour.palette_index = MotionBase + IndexW'(half_addr[7:4]);
			else if (half_addr[7:0] == '0)
				colour.palette_index = IndexW'(half_addr[9:8]);
			else
				return;
			colour.red   = level(word[8:6], intensity);
			colour.green = level(word[5:3], intensity);
			colour.blue  = level(word[2:0], intensity);
			expected_colors.push_back(colour);
		endtask

		task automatic check_result(logic [OutDataW-1:0] tdata);
			palette_color_t want;
			if (expected_colors.size() == 0) begin
				report("unexpected result, index", int'(tdata[5:0]), -1);
				return;
			end
			want = expected_colors.pop_front();
			if (tdata[5:0] != want.palette_index)
				report("palette_index", int'(tdata[5:0]), int'(want.palette_index));
			if (tdata[13:6] != want.red)
				report("red", int'(tdata[13:6]), int'(want.red));
			if (tdata[21:14] != want.green)
				report("green", int'(tdata[21:14]), int'(want.green));
			if (tdata[29:22] != want.blue)
				report("blue", int'(tdata[29:22]), int'(want.blue));
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;

	palette_scoreboard sb = new();
	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;
	logic              pressure_go = 1'b0;
	logic              rx_hold = 1'b0;
	int                cycle_count = 0;

	palette_ram_color_decoder i_dut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata
	);

	always #ClkHalf clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// hold the receiver off so the pipeline fills and stalls the input
	initial begin
		wait (pressure_go);
		repeat (40) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HoldCyc) @(posedge clk);
		rx_hold <= 1'b0;
	end

	task automatic send_write(input logic [AddrW-1:0] addr, input logic [ByteW-1:0] data);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= InDataW'({data, addr});
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_write(addr, data);
	endtask

	function automatic logic [HalfAw-1:0] pick_palette_addr();
		case ($urandom_range(2))
			0: return {6'b0, 4'($urandom)};
			1: return {2'b0, 4'($urandom), 4'b0};
			default: return {2'($urandom), 8'b0};
		endcase
	endfunction

	task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items);
		int                sent;
		logic [HalfAw-1:0] half_addr;
		sent = 0;
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		while (sent < n_items) begin
			if ($urandom_range(99) < 70) begin
				half_addr = pick_palette_addr();
				if ($urandom_range(1)) begin
					send_write({1'b1, half_addr}, 8'($urandom));
					send_write({1'b0, half_addr}, 8'($urandom));
				end else begin
					send_write({1'b0, half_addr}, 8'($urandom));
					send_write({1'b1, half_addr}, 8'($urandom));
				end
				sent += 2;
			end else begin
				send_write(AddrW'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (ResetCyc) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		send_write(11'h400, 8'hFF);
		send_write(11'h000, 8'hFF);
		send_write(11'h40F, 8'h0E);
		send_write(11'h00F, 8'h00);
		send_write(11'h001, 8'h01);
		send_write(11'h410, 8'h02);
		send_write(11'h010, 8'hFF);
		send_write(11'h0F0, 8'h5A);
		send_write(11'h4F0, 8'hA5);
		send_write(11'h500, 8'hFF);
		send_write(11'h100, 8'h3F);
		send_write(11'h600, 8'h81);
		send_write(11'h200, 8'hC0);
		send_write(11'h300, 8'h00);
		send_write(11'h700, 8'h7F);
		send_write(11'h7FF, 8'hFF);
		send_write(11'h3FF, 8'h00);
		send_write(11'h011, 8'hAA);
		send_write(11'h411, 8'h55);
		send_write(11'h080, 8'hFF);
		send_write(11'h4FF, 8'hF0);

		run_phase(36, 52, 330);
		run_phase(52, 36, 330);
		pressure_go <= 1'b1;
		run_phase(0, 0, 340);
		s_axis_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DrainCyc) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
sv/prc_pkg.sv
sv/prc_ram.sv
sv/prc_decode.sv
sv/palette_ram_color_decoder.sv
test/tb_palette_ram_color_decoder.sv
